/* hw/rtl/epoch_seconds_to_calendar_macros.svh */
// ============================================================================
// Assertion macros for the epoch seconds to calendar converter
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ============================================================================
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// General property check
`define ES2C_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Signal holds in the cycle after cond
`define ES2C_HOLD(label, cond, sig, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |=> $stable(sig)) else $error(msg);

`endif

/* hw/rtl/es2c_pkg.sv */
// ============================================================================
// es2c_pkg
// Constants, types and the month length table of the calendar converter.
// ============================================================================
package es2c_pkg;

   // calendar constants
   localparam int BASE_YEAR   = 1970;
   localparam int ZONE_RESET  = 28800;
   localparam int SEC_PER_MIN = 60;
   localparam int MIN_PER_HR  = 60;
   localparam int HR_PER_DAY  = 24;
   localparam int DAYS_YEAR   = 365;
   localparam int DAYS_LEAP   = 366;
   localparam int LAST_MONTH  = 11;

   // start phase of the leap-year cycle counters
   localparam int BASE_MOD4   = BASE_YEAR % 4;
   localparam int BASE_MOD100 = BASE_YEAR % 100;
   localparam int BASE_MOD400 = BASE_YEAR % 400;

   // digit-wise division by 60 and 24: q = (v * RECIP) >> RECIP_SHIFT,
   // exact for a dividend of one remainder above one 16-bit digit
   localparam int DIGIT_BITS  = 16;
   localparam int RECIP_BITS  = 24;
   localparam int RECIP_SHIFT = 28;
   localparam int RECIP_60    = (2**RECIP_SHIFT + MIN_PER_HR - 1) / MIN_PER_HR;
   localparam int RECIP_24    = (2**RECIP_SHIFT + HR_PER_DAY - 1) / HR_PER_DAY;

   // result field widths and the total and byte-padded width of rsp_tdata
   localparam int YEAR_BITS  = 12;
   localparam int MONTH_BITS = 4;
   localparam int DAY_BITS   = 5;
   localparam int HOUR_BITS  = 5;
   localparam int MIN_BITS   = 6;
   localparam int SEC_BITS   = 6;
   localparam int ZONE_BITS  = 16;
   localparam int RSP_BITS   = YEAR_BITS + MONTH_BITS + DAY_BITS + HOUR_BITS
                               + MIN_BITS + SEC_BITS;
   localparam int RSP_BYTES_BITS = ((RSP_BITS + 7) / 8) * 8;

   // year tracker control
   typedef struct packed {
      logic restart;   // load the base year
      logic advance;   // step to the next year
   } leap_ctl_type;

   // days in month, month index 0 is January
   function automatic logic [4:0] month_days(input logic leap, input logic [3:0] mon);
      logic [4:0] len;
      begin
         unique case (mon)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3,
            4'd5,
            4'd8,
            4'd10:   len = 5'd30;
            default: len = 5'd31;
         endcase
         return len;
      end
   endfunction

endpackage

/* hw/rtl/es2c_sub.sv */
// ============================================================================
// es2c_sub
// Shared compare and subtract unit: a >= b and a - b.
// ============================================================================
module es2c_sub #(
   parameter int W = 17
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic         ge,
   output logic [W-1:0] diff
);

   logic [W:0] wide;

   // one subtractor, borrow gives the compare
   assign wide = {1'b0, a} - {1'b0, b};
   assign ge   = ~wide[W];
   assign diff = wide[W-1:0];

endmodule

/* hw/rtl/es2c_leap.sv */
// ============================================================================
// es2c_leap
// Year counter with mod 4/100/400 phase counters for the Gregorian leap rule.
// ============================================================================
module es2c_leap
   import es2c_pkg::*;
#(
   parameter int YEAR_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  leap_ctl_type      ctl,
   output logic [YEAR_W-1:0] year,
   output logic              leap
);

   logic [YEAR_W-1:0] year_ff, year_in;
   logic [1:0]        mod4_ff, mod4_in;
   logic [6:0]        mod100_ff, mod100_in;
   logic [8:0]        mod400_ff, mod400_in;

   // next year and phase counters
   always_comb begin
      year_in   = year_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      if (ctl.restart) begin
         year_in   = YEAR_W'(BASE_YEAR);
         mod4_in   = 2'(BASE_MOD4);
         mod100_in = 7'(BASE_MOD100);
         mod400_in = 9'(BASE_MOD400);
      end else if (ctl.advance) begin
         year_in   = year_ff + 1'b1;
         mod4_in   = mod4_ff + 1'b1;
         mod100_in = (mod100_ff == 7'd99)  ? 7'd0 : mod100_ff + 1'b1;
         mod400_in = (mod400_ff == 9'd399) ? 9'd0 : mod400_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff   <= YEAR_W'(BASE_YEAR);
         mod4_ff   <= 2'(BASE_MOD4);
         mod100_ff <= 7'(BASE_MOD100);
         mod400_ff <= 9'(BASE_MOD400);
      end else begin
         year_ff   <= year_in;
         mod4_ff   <= mod4_in;
         mod100_ff <= mod100_in;
         mod400_ff <= mod400_in;
      end
   end

   assign year = year_ff;
   assign leap = ((mod4_ff == 2'd0) && (mod100_ff != 7'd0)) || (mod400_ff == 9'd0);

endmodule

/* hw/rtl/epoch_seconds_to_calendar.sv */
// ============================================================================
// epoch_seconds_to_calendar
// Converts seconds since 1970-01-01 UTC plus a zone offset to a civil date and time.
// ============================================================================
// Usage:
//   req_* carries one epoch count per request; rsp_* returns one date per
//   request. csr_wr_en/csr_wr_data set the zone offset in seconds (reset
//   value 28800); the user must write it only while no request is in
//   flight, as the block does not enforce this. One request at a time:
//   req_tready is high only while the sequencer is idle. A request goes
//   through a load step, division by 60, 60 and 24 (each as three 16-bit
//   digits at EPOCH_BITS = 32, with a reciprocal multiply step and a
//   remainder step per digit), the year peel (one whole year per cycle,
//   plus a final compare), up to 12 month steps and an output step. The
//   year peel on the shared compare/subtract unit takes most of its time.
//   The result sits in an output register; the next request is accepted
//   while it waits. If rsp_tready stays low, a second finished result
//   waits in the sequencer until the register frees.
//   Reset is synchronous: it empties the output, idles the sequencer and
//   restores the zone offset.
// ============================================================================
module epoch_seconds_to_calendar
   import es2c_pkg::*;
#(
   parameter int EPOCH_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: [EPOCH_BITS-1:0] epoch_seconds, zero padded to bytes
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((EPOCH_BITS+7)/8)*8-1:0]     req_tdata,
   // response: year[11:0] month[15:12] day[20:16] hour[25:21]
   //           minute[31:26] second[37:32], zero padded to bytes
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [RSP_BYTES_BITS-1:0]           rsp_tdata,
   // zone offset register
   input  logic                                csr_wr_en,
   input  logic [ZONE_BITS-1:0]                csr_wr_data
);

   localparam int T_W    = EPOCH_BITS + 1;
   localparam int DIG_N  = (T_W + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int Q_W    = DIG_N * DIGIT_BITS;
   localparam int V_W    = DIGIT_BITS + 6;
   localparam int P_W    = V_W + RECIP_BITS;
   localparam int DAYS_W = EPOCH_BITS - 15;
   localparam int YEAR_W = EPOCH_BITS - 16;
   localparam int CNT_W  = $clog2(DIG_N);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_YEAR   = 3'd2;
   localparam logic [2:0] ST_MONTH  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   // division stage select
   localparam logic [1:0] DIV_SEC  = 2'd0;
   localparam logic [1:0] DIV_MIN  = 2'd1;
   localparam logic [1:0] DIV_HR   = 2'd2;

   logic [2:0]           state_ff, state_in;
   logic [ZONE_BITS-1:0] zone_ff;
   logic [Q_W-1:0]       quo_ff, quo_in;
   logic [5:0]           rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 phase_ff, phase_in;
   logic [DIGIT_BITS-1:0] qdig_ff, qdig_in;
   logic [1:0]           sel_ff, sel_in;
   logic [SEC_BITS-1:0]  sec_ff, sec_in;
   logic [MIN_BITS-1:0]  min_ff, min_in;
   logic [HOUR_BITS-1:0] hr_ff, hr_in;
   logic [DAYS_W-1:0]    days_ff, days_in;
   logic [3:0]           mon_ff, mon_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_BYTES_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [DAYS_W-1:0]    alu_a, alu_b, alu_diff;
   logic                 alu_ge;
   logic [V_W-1:0]       div_v, div_qw, div_qd, div_r;
   logic [RECIP_BITS-1:0] recip;
   logic [P_W-1:0]       div_prod;
   logic [DIGIT_BITS-1:0] div_q;
   logic                 div_last;
   logic [YEAR_W-1:0]    year;
   logic                 leap;
   leap_ctl_type         leap_ctl;
   logic                 req_fire, out_free;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign div_last = (cnt_ff == CNT_W'(DIG_N - 1));

   // one digit of the division by 60 or 24: reciprocal multiply for the
   // quotient digit, then remainder from the registered digit
   assign div_v    = {rem_ff, quo_ff[Q_W-1 -: DIGIT_BITS]};
   assign recip    = (sel_ff == DIV_HR) ? RECIP_BITS'(RECIP_24) : RECIP_BITS'(RECIP_60);
   assign div_prod = P_W'(div_v) * P_W'(recip);
   assign div_q    = div_prod[RECIP_SHIFT +: DIGIT_BITS];
   assign div_qw   = V_W'(qdig_ff);
   // 24 q = 16 q + 8 q, 60 q = 64 q - 4 q
   assign div_qd   = (sel_ff == DIV_HR) ? ((div_qw << 4) + (div_qw << 3))
                                        : ((div_qw << 6) - (div_qw << 2));
   assign div_r    = div_v - div_qd;

   // operand select for the shared unit
   always_comb begin
      unique case (state_ff)
         ST_YEAR: begin
            alu_a = days_ff;
            alu_b = leap ? DAYS_W'(DAYS_LEAP) : DAYS_W'(DAYS_YEAR);
         end
         ST_MONTH: begin
            alu_a = days_ff;
            alu_b = DAYS_W'(month_days(leap, mon_ff));
         end
         default: begin
            alu_a = days_ff;
            alu_b = '0;
         end
      endcase
   end

   es2c_sub #(.W(DAYS_W)) u_sub (
      .a    (alu_a),
      .b    (alu_b),
      .ge   (alu_ge),
      .diff (alu_diff)
   );

   es2c_leap #(.YEAR_W(YEAR_W)) u_leap (
      .clock (clock),
      .reset (reset),
      .ctl   (leap_ctl),
      .year  (year),
      .leap  (leap)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      qdig_in      = qdig_ff;
      sel_in       = sel_ff;
      sec_in       = sec_ff;
      min_in       = min_ff;
      hr_in        = hr_ff;
      days_in      = days_ff;
      mon_in       = mon_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      leap_ctl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               quo_in   = Q_W'(req_tdata[EPOCH_BITS-1:0]) + Q_W'(zone_ff);
               rem_in   = '0;
               cnt_in   = '0;
               phase_in = 1'b0;
               sel_in   = DIV_SEC;
               leap_ctl.restart = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!phase_ff) begin
               // quotient digit from the top digit and running remainder
               qdig_in  = div_q;
               phase_in = 1'b1;
            end else begin
               // remainder carries on, quotient digit shifts in at the bottom
               phase_in = 1'b0;
               quo_in   = {quo_ff[Q_W-DIGIT_BITS-1:0], qdig_ff};
               rem_in   = div_r[5:0];
               cnt_in   = cnt_ff + 1'b1;
               if (div_last) begin
                  cnt_in = '0;
                  rem_in = '0;
                  unique case (sel_ff)
                     DIV_SEC: begin
                        sec_in = div_r[5:0];
                        sel_in = DIV_MIN;
                     end
                     DIV_MIN: begin
                        min_in = div_r[5:0];
                        sel_in = DIV_HR;
                     end
                     default: begin
                        hr_in    = div_r[4:0];
                        days_in  = quo_in[DAYS_W-1:0];
                        state_in = ST_YEAR;
                     end
                  endcase
               end
            end
         end
         ST_YEAR: begin
            // peel one whole year per cycle
            if (alu_ge) begin
               days_in          = alu_diff;
               leap_ctl.advance = 1'b1;
            end else begin
               mon_in   = '0;
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (alu_ge && (mon_ff < 4'(LAST_MONTH))) begin
               days_in = alu_diff;
               mon_in  = mon_ff + 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_BYTES_BITS'({sec_ff, min_ff, hr_ff,
                                               days_ff[4:0] + 5'd1,
                                               mon_ff + 4'd1,
                                               year[YEAR_BITS-1:0]});
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         zone_ff      <= ZONE_BITS'(ZONE_RESET);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            zone_ff <= csr_wr_data;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      phase_ff    <= phase_in;
      qdig_ff     <= qdig_in;
      sel_ff      <= sel_in;
      sec_ff      <= sec_in;
      min_ff      <= min_in;
      hr_ff       <= hr_in;
      days_ff     <= days_in;
      mon_ff      <= mon_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hw/rtl/es2c_chk.sv */
// ============================================================================
// es2c_chk
// Port-level checker for the calendar converter, bound to the top level.
// ============================================================================
`include "epoch_seconds_to_calendar_macros.svh"

module es2c_chk #(
   parameter int EPOCH_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [((EPOCH_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [39:0]                     rsp_tdata
);

   logic stall;
   logic req_fire;

   assign stall    = rsp_tvalid && !rsp_tready;
   assign req_fire = req_tvalid && req_tready && (req_tdata == req_tdata);

   // a stalled response stays put
   `ES2C_HOLD(a_rsp_valid_hold, stall, rsp_tvalid, "response dropped while stalled")
   `ES2C_HOLD(a_rsp_data_hold, stall, rsp_tdata, "response changed while stalled")

   // the converter is busy right after it takes a request
   `ES2C_ASSERT(a_busy_after_req, req_fire |=> !req_tready, "ready right after a request")

   // calendar fields stay in range
   `ES2C_ASSERT(a_date_range, rsp_tvalid |-> (rsp_tdata[15:12] != 4'd0) &&
      (rsp_tdata[15:12] <= 4'd12) && (rsp_tdata[20:16] != 5'd0),
      "month or day out of range")
   `ES2C_ASSERT(a_time_range, rsp_tvalid |-> (rsp_tdata[25:21] <= 5'd23) &&
      (rsp_tdata[31:26] <= 6'd59) && (rsp_tdata[37:32] <= 6'd59),
      "hour, minute or second out of range")

endmodule

bind epoch_seconds_to_calendar es2c_chk #(.EPOCH_BITS(EPOCH_BITS)) u_es2c_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
